FILE: design/assert_macros.svh
// Assertion macros shared by the step-rate generator modules.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRG_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/srg_pkg.sv
// Types, constants and period helpers for the step-rate generator.
// No dependencies; imported by every other design file but the assertion macro header.
package srg_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_BACK = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_ENTRY    = 3'd1;
  localparam logic [2:0] REG_NOMINAL  = 3'd2;
  localparam logic [2:0] REG_INC      = 3'd3;
  localparam logic [2:0] REG_ACCEL    = 3'd4;
  localparam logic [2:0] REG_INTERVAL = 3'd5;

  typedef enum logic [2:0] {
    PH_STOP  = 3'd0,
    PH_START = 3'd1,
    PH_ACC   = 3'd2,
    PH_NOM   = 3'd3,
    PH_DEC   = 3'd4,
    PH_BACK  = 3'd5
  } srg_phase_t;

  localparam logic [31:0] CYC_LIM_DIV1    = 32'h0000_FFFF;
  localparam logic [31:0] CYC_LIM_DIV8    = 32'h0007_FFFF;
  localparam logic [31:0] CYC_LIM_DIV64   = 32'h003F_FFFF;
  localparam logic [31:0] CYC_LIM_DIV256  = 32'h00FF_FFFF;
  localparam logic [31:0] CYC_LIM_DIV1024 = 32'h03FF_FFFF;
  localparam logic [26:0] PERIOD_MAX      = 27'h3FF_FC00;

  localparam logic [9:0] PSC_1    = 10'd0;
  localparam logic [9:0] PSC_8    = 10'd7;
  localparam logic [9:0] PSC_64   = 10'd63;
  localparam logic [9:0] PSC_256  = 10'd255;
  localparam logic [9:0] PSC_1024 = 10'd1023;

  typedef struct packed {
    logic [1:0]  kind;
    logic        electrode_touched;
    logic        direction_forward;
    logic [19:0] gap_speed;
    logic [15:0] back_distance;
  } srg_in_t;

  typedef struct packed {
    logic               step_pulse;
    logic signed [31:0] position;
    logic [2:0]         motion_phase;
    logic               timer_stopped;
    logic [9:0]         prescaler_minus_one;
    logic [15:0]        period_ceiling;
    logic [19:0]        current_speed;
  } srg_out_t;

  typedef struct packed {
    logic        machining_mode;
    logic [19:0] start_rate;
    logic [19:0] cruise_rate;
    logic [19:0] speed_increment;
    logic [31:0] accel_distance;
    logic [25:0] speed_change_interval;
  } srg_cfg_t;

  typedef struct packed {
    logic latch;
    logic command;
    logic touch;
    logic start;
    logic div_start;
    logic period_load;
    logic half_add;
    logic acc_add;
    logic acc_cmp;
    logic speed_update;
    logic back_step;
    logic finish;
    logic pulse;
    logic count;
  } srg_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       machining;
    srg_phase_t phase;
    logic       due;
    logic       div_done;
  } srg_stat_t;

  typedef struct packed {
    logic [9:0]  psc_m1;
    logic [15:0] ceiling;
  } srg_timer_t;

  function automatic logic [26:0] round_period(input logic [31:0] cyc);
    logic [26:0] p;
    p = cyc[26:0];
    if (cyc <= CYC_LIM_DIV1) begin
      round_period = p;
    end else if (cyc <= CYC_LIM_DIV8) begin
      round_period = {p[26:3], 3'd0};
    end else if (cyc <= CYC_LIM_DIV64) begin
      round_period = {p[26:6], 6'd0};
    end else if (cyc <= CYC_LIM_DIV256) begin
      round_period = {p[26:8], 8'd0};
    end else if (cyc <= CYC_LIM_DIV1024) begin
      round_period = {p[26:10], 10'd0};
    end else begin
      round_period = PERIOD_MAX;
    end
  endfunction

  function automatic srg_timer_t split_period(input logic [26:0] p);
    logic [31:0] w;
    w = {5'd0, p};
    if (w <= CYC_LIM_DIV1) begin
      split_period = '{psc_m1: PSC_1, ceiling: p[15:0]};
    end else if (w <= CYC_LIM_DIV8) begin
      split_period = '{psc_m1: PSC_8, ceiling: p[18:3]};
    end else if (w <= CYC_LIM_DIV64) begin
      split_period = '{psc_m1: PSC_64, ceiling: p[21:6]};
    end else if (w <= CYC_LIM_DIV256) begin
      split_period = '{psc_m1: PSC_256, ceiling: p[23:8]};
    end else if (w <= CYC_LIM_DIV1024) begin
      split_period = '{psc_m1: PSC_1024, ceiling: p[25:10]};
    end else begin
      split_period = '{psc_m1: PSC_1024, ceiling: 16'hFFFF};
    end
  endfunction

endpackage

FILE: design/srg_if.sv
// Valid/ready channel interfaces for command input and step results.
// Depends on srg_pkg for the payload types.
interface srg_in_if import srg_pkg::*; ();
  logic    valid;
  logic    ready;
  srg_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srg_out_if import srg_pkg::*; ();
  logic     valid;
  logic     ready;
  srg_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/srg_cfg.sv
// APB-style configuration register file for the step-rate generator.
// Depends on srg_pkg for the configuration struct.
module srg_cfg
  import srg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output srg_cfg_t    cfg
);

  srg_cfg_t    cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.machining_mode        <= 1'b0;
      cfg_r.start_rate            <= 20'd100;
      cfg_r.cruise_rate           <= 20'd1000;
      cfg_r.speed_increment       <= 20'd50;
      cfg_r.accel_distance        <= 32'd1000;
      cfg_r.speed_change_interval <= 26'd720000;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:     cfg_r.machining_mode        <= pwdata[0];
        REG_ENTRY:    cfg_r.start_rate            <= pwdata[19:0];
        REG_NOMINAL:  cfg_r.cruise_rate           <= pwdata[19:0];
        REG_INC:      cfg_r.speed_increment       <= pwdata[19:0];
        REG_ACCEL:    cfg_r.accel_distance        <= pwdata;
        REG_INTERVAL: cfg_r.speed_change_interval <= pwdata[25:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:     prdata = {31'd0, cfg_r.machining_mode};
      REG_ENTRY:    prdata = {12'd0, cfg_r.start_rate};
      REG_NOMINAL:  prdata = {12'd0, cfg_r.cruise_rate};
      REG_INC:      prdata = {12'd0, cfg_r.speed_increment};
      REG_ACCEL:    prdata = cfg_r.accel_distance;
      REG_INTERVAL: prdata = {6'd0, cfg_r.speed_change_interval};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

FILE: design/srg_div.sv
// Radix-2 restoring divider: timer clock rate divided by speed.
// Depends on srg_pkg; one quotient bit per cycle, zero divisor gives all ones.
`include "assert_macros.svh"
module srg_div
  import srg_pkg::*;
#(
  parameter int CLOCK_TICKS_PER_US = 72
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam logic [31:0] CLK_HZ   = 32'(CLOCK_TICKS_PER_US * 1000000);
  localparam int          ITER     = 32;
  localparam int          CNT_W    = $clog2(ITER);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ITER - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [19:0]      rem_r;
  logic [19:0]      dvs_r;
  logic [31:0]      quo_r;
  logic [20:0]      shifted;
  logic [20:0]      diff;
  logic             ge;

  assign shifted  = {rem_r, quo_r[31]};
  assign diff     = shifted - {1'b0, dvs_r};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        rem_r <= 20'd0;
        dvs_r <= divisor;
        if (divisor == 20'd0) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          quo_r  <= CLK_HZ;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[19:0] : shifted[19:0];
        quo_r <= {quo_r[30:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  `SRG_ASSERT_NEXT(a_div_last_done, clk, rst_n, busy_r && (cnt_r == LAST_CNT), done_r, "divider missed done")

endmodule

FILE: design/srg_datapath.sv
// Datapath: motion state, time accumulator, speed ramp, period and result register.
// Depends on srg_pkg and srg_div; driven by srg_ctrl commands.
`include "assert_macros.svh"
module srg_datapath
  import srg_pkg::*;
#(
  parameter int CLOCK_TICKS_PER_US = 72
) (
  input  logic      clk,
  input  logic      rst_n,
  input  srg_cfg_t  cfg,
  input  srg_in_t   in_data,
  input  srg_cmd_t  cmd,
  output srg_stat_t stat,
  output srg_out_t  out_data
);

  logic [1:0]  kind_r;
  logic        touched_r;
  logic        fwd_r;
  logic [19:0] sp_in_r;
  logic [15:0] back_dist_r;
  srg_phase_t  phase_r, phase_nxt;
  logic [19:0] speed_r, speed_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [26:0] period_r, period_nxt;
  logic [31:0] steps_r, steps_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] back_left_r, back_left_nxt;
  logic        stopped_r, stopped_nxt;
  srg_out_t    out_r;

  logic        div_done;
  logic [31:0] div_quo;
  logic [32:0] addend;
  logic [32:0] acc_sum;
  logic [31:0] interval_w;
  logic        acc_gt;
  logic [20:0] ramp_sum;
  srg_timer_t  tmr;

  srg_div #(
    .CLOCK_TICKS_PER_US(CLOCK_TICKS_PER_US)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .divisor (speed_r),
    .done    (div_done),
    .quotient(div_quo)
  );

  assign interval_w = {6'd0, cfg.speed_change_interval};
  assign acc_gt     = acc_r > interval_w;
  assign addend     = cmd.half_add ? {7'd0, period_r[26:1]} : {6'd0, period_r};
  assign acc_sum    = {1'b0, acc_r} + addend;
  assign ramp_sum   = {1'b0, speed_r} + {1'b0, cfg.speed_increment};
  assign tmr        = split_period(period_r);

  assign stat.kind      = kind_r;
  assign stat.machining = cfg.machining_mode;
  assign stat.phase     = phase_r;
  assign stat.due       = acc_gt;
  assign stat.div_done  = div_done;
  assign out_data       = out_r;

  always_comb begin
    phase_nxt     = phase_r;
    speed_nxt     = speed_r;
    acc_nxt       = acc_r;
    period_nxt    = period_r;
    steps_nxt     = steps_r;
    pos_nxt       = pos_r;
    back_left_nxt = back_left_r;
    stopped_nxt   = stopped_r;

    if (cmd.latch) begin
      stopped_nxt = 1'b0;
    end
    if (cmd.command) begin
      if (kind_r == KIND_MOVE) begin
        phase_nxt = PH_START;
        steps_nxt = 32'd0;
      end else if (kind_r == KIND_BACK) begin
        phase_nxt     = PH_BACK;
        back_left_nxt = back_dist_r;
      end
    end
    if (cmd.touch && touched_r && (phase_r != PH_BACK)) begin
      phase_nxt = PH_DEC;
    end
    if (cmd.start) begin
      speed_nxt = cfg.start_rate;
      phase_nxt = PH_ACC;
    end
    if (cmd.period_load) begin
      period_nxt = round_period(div_quo);
    end
    if (cmd.half_add || cmd.acc_add) begin
      acc_nxt = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    end
    if (cmd.acc_cmp && acc_gt) begin
      acc_nxt = acc_r - interval_w;
    end
    if (cmd.speed_update) begin
      if (cfg.machining_mode) begin
        speed_nxt = sp_in_r;
      end else begin
        case (phase_r)
          PH_ACC: begin
            if (steps_r < cfg.accel_distance) begin
              if (ramp_sum >= {1'b0, cfg.cruise_rate}) begin
                speed_nxt = cfg.cruise_rate;
                phase_nxt = PH_NOM;
              end else begin
                speed_nxt = ramp_sum[19:0];
              end
            end
          end
          PH_DEC: begin
            if (speed_r > cfg.speed_increment) begin
              speed_nxt = speed_r - cfg.speed_increment;
            end else begin
              speed_nxt   = {1'b0, cfg.speed_increment[19:1]};
              phase_nxt   = PH_STOP;
              stopped_nxt = 1'b1;
              steps_nxt   = 32'd0;
            end
          end
          PH_NOM: speed_nxt = cfg.cruise_rate;
          default: begin
          end
        endcase
      end
    end
    if (cmd.back_step) begin
      if (back_left_r <= 16'd1) begin
        back_left_nxt = 16'd0;
        phase_nxt     = PH_STOP;
        stopped_nxt   = 1'b1;
      end else begin
        back_left_nxt = back_left_r - 16'd1;
      end
    end
    if (cmd.finish) begin
      if (cmd.pulse) begin
        pos_nxt = fwd_r ? pos_r + 32'd1 : pos_r - 32'd1;
      end
      if (cmd.count) begin
        steps_nxt = steps_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STOP;
      speed_r     <= 20'd0;
      acc_r       <= 32'd0;
      period_r    <= 27'd0;
      steps_r     <= 32'd0;
      pos_r       <= 32'd0;
      back_left_r <= 16'd0;
      stopped_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      speed_r     <= speed_nxt;
      acc_r       <= acc_nxt;
      period_r    <= period_nxt;
      steps_r     <= steps_nxt;
      pos_r       <= pos_nxt;
      back_left_r <= back_left_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r      <= in_data.kind;
      touched_r   <= in_data.electrode_touched;
      fwd_r       <= in_data.direction_forward;
      sp_in_r     <= in_data.gap_speed;
      back_dist_r <= in_data.back_distance;
    end
    if (cmd.finish) begin
      out_r.step_pulse          <= cmd.pulse;
      out_r.position            <= signed'(pos_nxt);
      out_r.motion_phase        <= phase_r;
      out_r.timer_stopped       <= stopped_r;
      out_r.prescaler_minus_one <= tmr.psc_m1;
      out_r.period_ceiling      <= tmr.ceiling;
      out_r.current_speed       <= speed_r;
    end
  end

  `SRG_ASSERT(a_half_in_accel, clk, rst_n, cmd.half_add, phase_r == PH_ACC, "half-period add outside acceleration")

endmodule

FILE: design/srg_ctrl.sv
// Sequencing controller: accepts transactions, steps the datapath, hands off results.
// Depends on srg_pkg for command, status and code definitions.
`include "assert_macros.svh"
module srg_ctrl
  import srg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  srg_stat_t stat,
  output srg_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_HALF,
    S_ACC_ADD,
    S_ACC_CMP,
    S_UPDATE,
    S_BACK,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RET_HALF,
    RET_BACK,
    RET_END
  } ret_t;

  state_t state_r;
  ret_t   ret_r;
  logic   pulse_r;
  logic   count_r;
  logic   out_valid_r;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.latch = in_valid;
      S_DISPATCH: begin
        if ((stat.kind == KIND_MOVE) || (stat.kind == KIND_BACK)) begin
          cmd.command = 1'b1;
        end else if ((stat.kind == KIND_TICK) && !stat.machining &&
                     (stat.phase != PH_STOP)) begin
          cmd.touch = 1'b1;
        end
      end
      S_PREP:     cmd.start = (stat.phase == PH_START);
      S_DIV_GO:   cmd.div_start = 1'b1;
      S_DIV_WAIT: cmd.period_load = stat.div_done;
      S_HALF:     cmd.half_add = 1'b1;
      S_ACC_ADD:  cmd.acc_add = 1'b1;
      S_ACC_CMP:  cmd.acc_cmp = 1'b1;
      S_UPDATE:   cmd.speed_update = 1'b1;
      S_BACK:     cmd.back_step = 1'b1;
      S_FINISH: begin
        cmd.finish = slot_free;
        cmd.pulse  = pulse_r;
        cmd.count  = count_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_END;
      pulse_r     <= 1'b0;
      count_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          pulse_r <= 1'b0;
          count_r <= 1'b0;
          if ((stat.kind == KIND_TICK) && stat.machining) begin
            pulse_r <= 1'b1;
            state_r <= S_ACC_ADD;
          end else if ((stat.kind == KIND_TICK) && (stat.phase != PH_STOP)) begin
            pulse_r <= 1'b1;
            count_r <= 1'b1;
            state_r <= S_PREP;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_PREP: begin
          if (stat.phase == PH_START) begin
            ret_r   <= RET_HALF;
            state_r <= S_DIV_GO;
          end else if (stat.phase == PH_BACK) begin
            ret_r   <= RET_BACK;
            state_r <= S_DIV_GO;
          end else begin
            state_r <= S_ACC_ADD;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            case (ret_r)
              RET_HALF: state_r <= S_HALF;
              RET_BACK: state_r <= S_BACK;
              default:  state_r <= S_FINISH;
            endcase
          end
        end
        S_HALF:    state_r <= S_ACC_ADD;
        S_ACC_ADD: state_r <= S_ACC_CMP;
        S_ACC_CMP: begin
          state_r <= stat.due ? S_UPDATE : S_FINISH;
        end
        S_UPDATE: begin
          ret_r   <= RET_END;
          state_r <= S_DIV_GO;
        end
        S_BACK: state_r <= S_FINISH;
        S_FINISH: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SRG_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, in_valid && in_ready, state_r == S_DISPATCH, "accepted transaction not dispatched")
  `SRG_ASSERT_NEXT(a_finish_presents, clk, rst_n, cmd.finish, out_valid_r, "finished transaction not presented")

endmodule

FILE: design/trapezoidal_step_rate_generator.sv
// Trapezoidal step-rate generator: controller, datapath with serial divider, APB registers.
// Result latency depends on the transaction: commands and idle ticks are quickest, then
// ticks without a speed update; speed updates, back-off steps and a move's first tick wait
// on the serial divider, which sets the throughput. One transaction is in flight at a time.
// A finished result waits in the output register while the next transaction is taken.
// Synchronous active-low reset: stopped, speed and position zero, registers to defaults.
module trapezoidal_step_rate_generator
  import srg_pkg::*;
#(
  parameter int CLOCK_TICKS_PER_US = 72
) (
  input  logic        clk,
  input  logic        rst_n,
  srg_in_if.sink      in_item,
  srg_out_if.source   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  srg_cfg_t  cfg;
  srg_cmd_t  cmd;
  srg_stat_t stat;

  srg_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  srg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .out_valid(out_res.valid),
    .out_ready(out_res.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srg_datapath #(
    .CLOCK_TICKS_PER_US(CLOCK_TICKS_PER_US)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_data (in_item.data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_res.data)
  );

endmodule
